/* rtl/hcbp_pkg.sv */
// Package for the Huffman code bit packer: request codes and field widths.
// Depends on nothing; the core takes it in by a wildcard import.
`default_nettype none

package hcbp_pkg;

  typedef logic [1:0] req_t;

  localparam req_t REQ_LOAD   = 2'd0;
  localparam req_t REQ_ENCODE = 2'd1;
  localparam req_t REQ_FLUSH  = 2'd2;

  localparam int BYTE_BITS = 8;
  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int PEND_W    = 7;
  localparam int CNT_W     = 3;
  localparam int NB_W      = 3;

endpackage

`default_nettype wire

/* rtl/hcbp_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used by the core for the code table.
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/huffman_code_bit_packer_core.sv */
// Huffman encoder back end: code-table memory and MSB-first bit packer.
// Depends on hcbp_pkg and hcbp_ram.
//
// The slave channel takes one word per request. tuser carries the request kind
// (load a table entry, encode a symbol or flush the pending bits); tdata
// carries the symbol, the code bits and the code length. A load writes the
// code table and gives nothing. An encode reads the symbol's entry, appends
// its code to the pending bits and gives every completed byte. A flush pads
// the pending bits with zeros and gives one byte if any bits were pending.
// The master channel gives one byte a word; tlast marks the last byte caused
// by a request.
// A request passes the registered table read and is then merged into the
// output register. A request is accepted every cycle while each gives at most
// one byte and the receiver does not stall; a request that gives several bytes
// holds the output register until its last byte is taken. When the receiver
// stalls, the byte waits in the output register and one more request waits
// behind the table read before tready falls.
// Reset empties the pipeline, clears the pending bits and marks every table
// entry as having a code length of zero; code bits are undefined until loaded.
`default_nettype none

module huffman_code_bit_packer_core import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN  = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // symbol [7:0], code_value [39:8], code_len [45:40], zero [47:46]
  input  wire logic [47:0] s_axis_tdata,
  // req_type [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_byte [7:0]
  output      logic [7:0]  m_axis_tdata,
  output      logic        m_axis_tlast
);

  localparam int ADDR_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ENTRY_W = CODE_W + LEN_W;
  localparam int MERGE_W = CODE_W + PEND_W;

  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  len_capped;
  req_t              in_req;
  logic              in_range;
  logic              accept;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] addr;

  logic [ENTRY_W-1:0] rd_entry;
  logic [ALPHABET_SIZE-1:0] loaded;

  logic a_valid;
  logic a_flush;
  logic a_hit;
  logic a_move;

  logic [PEND_W-1:0] pend_bits;
  logic [CNT_W-1:0]  pend_cnt;
  logic [PEND_W-1:0] pend_bits_next;

  logic [CODE_W-1:0] e_word;
  logic [NB_W-1:0]   e_cnt;
  logic              e_load_ok;

  logic [LEN_W-1:0]   eff_len;
  logic [CODE_W:0]    code_mask;
  logic [CODE_W-1:0]  code_m;
  logic [MERGE_W-1:0] merged;
  logic [MERGE_W-1:0] full;
  logic [MERGE_W-1:0] aligned;
  logic [LEN_W-1:0]   total;
  logic [CNT_W-1:0]   rem;
  logic [NB_W-1:0]    nbytes;
  logic [LEN_W-1:0]   left_sh;
  logic [BYTE_BITS-1:0] rem_mask;
  logic [BYTE_BITS-1:0] flush_byte;

  assign in_symbol = s_axis_tdata[7:0];
  assign in_code   = s_axis_tdata[39:8];
  assign in_len    = s_axis_tdata[45:40];
  assign in_req    = s_axis_tuser;
  assign in_range  = {1'b0, in_symbol} < 9'(ALPHABET_SIZE);
  assign addr      = in_symbol[ADDR_W-1:0];

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign wr_en      = accept && (in_req == REQ_LOAD) && in_range;
  assign rd_en      = accept && (in_req == REQ_ENCODE) && in_range;
  assign len_capped = (in_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_len;

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (1 << ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata ({len_capped, in_code}),
    .re    (rd_en),
    .raddr (addr),
    .rdata (rd_entry)
  );

  assign e_load_ok     = (e_cnt == '0) || ((e_cnt == NB_W'(1)) && m_axis_tready);
  assign a_move        = a_valid && e_load_ok;
  assign s_axis_tready = !a_valid || a_move;

  // Read request stage and the per-entry loaded flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_flush <= 1'b0;
      a_hit   <= 1'b0;
      loaded  <= '0;
    end else begin
      if (wr_en) begin
        loaded[addr] <= 1'b1;
      end
      if (s_axis_tready) begin
        a_valid <= rd_en || (accept && (in_req == REQ_FLUSH));
        a_flush <= in_req == REQ_FLUSH;
        a_hit   <= loaded[addr];
      end
    end
  end

  // Merge of the pending bits with the code that was read.
  always_comb begin
    eff_len        = a_hit ? rd_entry[ENTRY_W-1:CODE_W] : '0;
    code_mask      = ((CODE_W+1)'(1) << eff_len) - (CODE_W+1)'(1);
    code_m         = rd_entry[CODE_W-1:0] & code_mask[CODE_W-1:0];
    merged         = (MERGE_W'(pend_bits) << eff_len) | MERGE_W'(code_m);
    total          = LEN_W'(pend_cnt) + eff_len;
    rem            = total[CNT_W-1:0];
    nbytes         = total[LEN_W-1:CNT_W];
    full           = merged >> rem;
    left_sh        = LEN_W'(CODE_W) - {nbytes, 3'b000};
    aligned        = full << left_sh;
    rem_mask       = (BYTE_BITS'(1) << rem) - BYTE_BITS'(1);
    pend_bits_next = merged[PEND_W-1:0] & rem_mask[PEND_W-1:0];
    flush_byte     = {1'b0, pend_bits} << (4'(BYTE_BITS) - {1'b0, pend_cnt});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_cnt     <= '0;
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else if (a_move) begin
      if (a_flush) begin
        e_cnt     <= (pend_cnt != '0) ? NB_W'(1) : '0;
        pend_bits <= '0;
        pend_cnt  <= '0;
      end else begin
        e_cnt     <= nbytes;
        pend_bits <= pend_bits_next;
        pend_cnt  <= rem;
      end
    end else if (m_axis_tvalid && m_axis_tready) begin
      e_cnt <= e_cnt - NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      if (a_flush) begin
        e_word <= {flush_byte, {(CODE_W-BYTE_BITS){1'b0}}};
      end else begin
        e_word <= aligned[CODE_W-1:0];
      end
    end else if (m_axis_tvalid && m_axis_tready) begin
      e_word <= e_word << BYTE_BITS;
    end
  end

  assign m_axis_tvalid = e_cnt != '0;
  assign m_axis_tdata  = e_word[CODE_W-1:CODE_W-BYTE_BITS];
  assign m_axis_tlast  = e_cnt == NB_W'(1);

endmodule

`default_nettype wire

/* rtl/hcbp_checker.sv */
// Port-level checks for the Huffman code bit packer core, and the bind that
// attaches them. Depends on huffman_code_bit_packer_core.
`default_nettype none

module hcbp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // A stalled output word holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // The input only stalls behind a word waiting at the output.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with the output empty");

  // A byte that is not the last of its request is always followed by another.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("bytes of a request were lost");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word present after reset");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
